@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wft check failed");

// The consequent must hold in the cycle after the antecedent.
`define WFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wft check failed");

`endif

@@ src/wft_pkg.sv @@
`timescale 1ns / 1ps

package wft_pkg;

  localparam int OFFSET_BITS      = 32;
  localparam int MAX_VARINT_BYTES = 10;
  localparam int VARINT_BITS      = 7;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_AW          = $clog2(FIFO_DEPTH);

  // Wire types carried in the low three bits of a tag.
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED8  = 3'd3;
  localparam logic [2:0] WT_FIXED16 = 3'd4;
  localparam logic [2:0] WT_FIXED32 = 3'd5;
  localparam logic [2:0] WT_BAD_LO  = 3'd6;
  localparam logic [2:0] WT_BAD_HI  = 3'd7;

  typedef enum logic [2:0] {
    ST_FIELD       = 3'd0,
    ST_DONE        = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_LEN_PAST    = 3'd3,
    ST_INVALID     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [60:0] field_id;
    logic [2:0]  wire_type;
    logic [63:0] field_value;
    logic [31:0] field_offset;
    logic        last_of_run;
  } out_item_t;

  // Number of value bytes for the fixed-size wire types.
  function automatic logic [3:0] fixed_len(input logic [2:0] wtype);
    logic [3:0] len;
    case (wtype)
      WT_FIXED64: len = 4'd8;
      WT_FIXED8:  len = 4'd1;
      WT_FIXED16: len = 4'd2;
      WT_FIXED32: len = 4'd4;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

@@ src/wire_format_field_tokenizer.sv @@
`timescale 1ns / 1ps

// Splits a serialized wire-format buffer, presented one byte per item, into
// field records. Each accepted byte is decoded in the cycle it is taken and its
// results (none, one or two) enter a four-entry result queue; a byte may be
// accepted every cycle while the queue holds at most two results, so the
// sustained rate is one byte per cycle, falling only when the consumer stalls.
// A byte that yields two results (a field that completes on the marked last
// byte) always follows one that yields none, so it never fills the queue on
// its own. Results appear on the output at the earliest in the cycle after
// their byte is taken.
// A field record is issued on the byte that completes its value, for
// length-delimited fields as soon as the length is known; errors stop the
// parse until the marked last byte, after which a new buffer starts at offset
// zero.
module wire_format_field_tokenizer
  import wft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARVAL  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t                 phase_r,  phase_nxt;
  logic [63:0]            acc_r,    acc_nxt;
  logic [3:0]             cnt_r,    cnt_nxt;
  logic [63:0]            tag_r,    tag_nxt;
  logic [63:0]            rem_r,    rem_nxt;
  logic [OFFSET_BITS-1:0] pos_r,    pos_nxt;
  logic [OFFSET_BITS-1:0] fstart_r, fstart_nxt;
  logic                   stop_r,   stop_nxt;

  out_item_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]       fill_r,   fill_nxt;

  logic                   in_take;
  logic                   out_take;
  logic [7:0]             b;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [6:0]             vsh;
  logic [63:0]            vacc;
  logic [5:0]             fsh;
  logic [63:0]            facc;
  logic [3:0]             cnt_inc;
  logic                   v_done;
  logic                   v_long;
  logic [63:0]            rem_dec;
  logic                   rec0_v, rec1_v;
  out_item_t              rec0, rec1;
  out_item_t              push0, push1;
  logic [1:0]             push_cnt;

  function automatic out_item_t make_rec(input status_t st, input logic [63:0] tag,
                                         input logic [63:0] val,
                                         input logic [OFFSET_BITS-1:0] off);
    out_item_t rec;
    rec.status       = st;
    rec.field_id     = tag[63:3];
    rec.wire_type    = tag[2:0];
    rec.field_value  = val;
    rec.field_offset = 32'(off);
    rec.last_of_run  = 1'b0;
    return rec;
  endfunction

  assign in_stall  = fill_r > (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = fill_r != '0;
  assign out_data  = fifo_r[rd_ptr_r];
  assign out_take  = out_valid && !out_stall;

  assign b        = in_data.data_byte;
  assign pos_next = pos_r + 1'b1;
  assign cnt_inc  = cnt_r + 4'd1;

  // Varint step: seven payload bits per byte, bits past 64 are dropped.
  assign vsh    = 7'(cnt_r) * 7'(VARINT_BITS);
  assign vacc   = (vsh < 7'd64) ? (acc_r | (64'(b[6:0]) << vsh)) : acc_r;
  assign v_done = !b[7];
  assign v_long = b[7] && (cnt_inc >= 4'(MAX_VARINT_BYTES));

  // Fixed step: little-endian bytes.
  assign fsh  = {cnt_r[2:0], 3'b000};
  assign facc = (cnt_r < 4'd8) ? (acc_r | (64'(b) << fsh)) : acc_r;

  assign rem_dec = (rem_r != '0) ? rem_r - 64'd1 : rem_r;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    tag_nxt    = tag_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    fstart_nxt = fstart_r;
    stop_nxt   = stop_r;
    rec0_v     = 1'b0;
    rec1_v     = 1'b0;
    rec0       = '0;
    rec1       = '0;

    if (!stop_r) begin
      case (phase_r)
        PH_TAG: begin
          if (cnt_r == '0) begin
            fstart_nxt = pos_r;
          end
          acc_nxt = vacc;
          cnt_nxt = cnt_inc;
          if (v_long) begin
            rec0_v   = 1'b1;
            rec0     = make_rec(ST_TRUNCATED, '0, '0, pos_next);
            stop_nxt = 1'b1;
          end else if (v_done) begin
            tag_nxt = vacc;
            acc_nxt = '0;
            cnt_nxt = '0;
            case (vacc[2:0])
              WT_VARINT: phase_nxt = PH_VARVAL;
              WT_LEN:    phase_nxt = PH_LEN;
              WT_FIXED64, WT_FIXED8, WT_FIXED16, WT_FIXED32: phase_nxt = PH_FIXED;
              default: begin
                rec0_v   = 1'b1;
                rec0     = make_rec(ST_INVALID, vacc, '0, pos_next);
                stop_nxt = 1'b1;
              end
            endcase
          end
        end
        PH_VARVAL, PH_LEN: begin
          acc_nxt = vacc;
          cnt_nxt = cnt_inc;
          if (v_long) begin
            rec0_v   = 1'b1;
            rec0     = make_rec(ST_TRUNCATED, tag_r, '0, pos_next);
            stop_nxt = 1'b1;
          end else if (v_done) begin
            rec0_v = 1'b1;
            rec0   = make_rec(ST_FIELD, tag_r, vacc, fstart_r);
            // A zero length has no payload to skip.
            if (phase_r == PH_LEN && vacc != '0) begin
              rem_nxt   = vacc;
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_TAG;
            end
            acc_nxt = '0;
            cnt_nxt = '0;
          end
        end
        PH_FIXED: begin
          acc_nxt = facc;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= fixed_len(tag_r[2:0])) begin
            rec0_v    = 1'b1;
            rec0      = make_rec(ST_FIELD, tag_r, facc, fstart_r);
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_TAG;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = PH_TAG;
          end
        end
        default: begin
        end
      endcase
    end

    if (in_data.end_of_buffer) begin
      if (!stop_nxt) begin
        rec1_v = 1'b1;
        if (phase_nxt == PH_TAG && cnt_nxt == '0) begin
          rec1 = make_rec(ST_DONE, '0, '0, pos_next);
        end else if (phase_nxt == PH_PAYLOAD) begin
          rec1 = make_rec(ST_LEN_PAST, tag_nxt, rem_nxt, pos_next);
        end else if (phase_nxt == PH_TAG) begin
          rec1 = make_rec(ST_TRUNCATED, '0, '0, pos_next);
        end else begin
          rec1 = make_rec(ST_TRUNCATED, tag_nxt, '0, pos_next);
        end
      end
      phase_nxt  = PH_TAG;
      acc_nxt    = '0;
      cnt_nxt    = '0;
      tag_nxt    = '0;
      rem_nxt    = '0;
      pos_nxt    = '0;
      fstart_nxt = '0;
      stop_nxt   = 1'b0;
    end else begin
      pos_nxt = pos_next;
    end
  end

  // Queue write: the first result of a byte goes to the write pointer, a
  // second one to the slot after it. Only the final one carries last_of_run.
  always_comb begin
    push0 = rec0_v ? rec0 : rec1;
    push1 = rec1;
    push0.last_of_run = !(rec0_v && rec1_v);
    push1.last_of_run = 1'b1;
    push_cnt = in_take ? (2'(rec0_v) + 2'(rec1_v)) : 2'd0;
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(out_take);
    fill_nxt   = fill_r + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      acc_r    <= '0;
      cnt_r    <= '0;
      tag_r    <= '0;
      rem_r    <= '0;
      pos_r    <= '0;
      fstart_r <= '0;
      stop_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (in_take) begin
        phase_r  <= phase_nxt;
        acc_r    <= acc_nxt;
        cnt_r    <= cnt_nxt;
        tag_r    <= tag_nxt;
        rem_r    <= rem_nxt;
        pos_r    <= pos_nxt;
        fstart_r <= fstart_nxt;
        stop_r   <= stop_nxt;
        if (push_cnt != 2'd0) begin
          fifo_r[wr_ptr_r] <= push0;
        end
        if (push_cnt == 2'd2) begin
          fifo_r[wr_ptr_r + FIFO_AW'(1)] <= push1;
        end
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

@@ src/wft_checker.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module wft_checker
  import wft_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic field_rec;
  logic end_rec;
  logic done_rec;
  logic done_empty;

  assign field_rec  = out_valid && out_data.status == ST_FIELD;
  assign end_rec    = out_valid && out_data.status != ST_FIELD;
  assign done_rec   = out_valid && out_data.status == ST_DONE;
  assign done_empty = out_data.field_id == '0 && out_data.wire_type == '0 &&
                      out_data.field_value == '0;

  `WFT_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_valid && out_stall, out_valid)
  `WFT_ASSERT_NEXT(a_out_data_held, clk, rst_n, out_valid && out_stall, $stable(out_data))
  // A field record never carries one of the two undefined wire types.
  `WFT_ASSERT_SAME(a_field_type_ok, clk, rst_n, field_rec, out_data.wire_type[2:1] != 2'b11)
  // Completion and error records always close the run of their byte.
  `WFT_ASSERT_SAME(a_end_is_last, clk, rst_n, end_rec, out_data.last_of_run)
  // A completion record has nothing decoded in it.
  `WFT_ASSERT_SAME(a_done_empty, clk, rst_n, done_rec, done_empty)

endmodule

bind wire_format_field_tokenizer wft_checker u_wft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ dv/field_record_tracker_pkg.sv @@
`timescale 1ns / 1ps

package field_record_tracker_pkg;
  import wft_pkg::*;

  class field_record_tracker;
    typedef enum {AWAIT_TAG, VARINT_VALUE, FIXED_VALUE, LENGTH_VALUE, SKIP_PAYLOAD} phase_e;
    typedef enum {VARINT_MORE, VARINT_DONE, VARINT_TOO_LONG} varint_e;

    phase_e      phase;
    logic [63:0] acc;
    logic [3:0]  count;
    logic [63:0] tag;
    logic [63:0] remaining;
    logic [31:0] pos;
    logic [31:0] start;
    bit          halted;
    out_item_t   awaited_records[$];
    int          failures;

    function new();
      restart();
      failures = 0;
    endfunction

    function void restart();
      phase     = AWAIT_TAG;
      acc       = '0;
      count     = '0;
      tag       = '0;
      remaining = '0;
      pos       = '0;
      start     = '0;
      halted    = 1'b0;
    endfunction

    // Seven payload bits per byte; anything that would land above bit 63 is lost.
    function varint_e absorb_varint(logic [7:0] b);
      int unsigned shift;
      shift = 7 * count;
      if (shift < 64) acc |= {57'd0, b[6:0]} << shift;
      count++;
      if (!b[7]) return VARINT_DONE;
      return (count >= MAX_VARINT_BYTES) ? VARINT_TOO_LONG : VARINT_MORE;
    endfunction

    function out_item_t record(status_t st, logic [63:0] t, logic [63:0] v,
                               logic [31:0] off);
      out_item_t r;
      r.status       = st;
      r.field_id     = t[63:3];
      r.wire_type    = t[2:0];
      r.field_value  = v;
      r.field_offset = off;
      r.last_of_run  = 1'b0;
      return r;
    endfunction

    function void note_byte(in_item_t it);
      out_item_t   made[$];
      logic [31:0] past;
      logic [3:0]  need;
      varint_e     step;
      past = pos + 32'd1;
      if (!halted) begin
        case (phase)
          AWAIT_TAG: begin
            if (count == 0) begin
              start = pos;
              acc   = '0;
            end
            step = absorb_varint(it.data_byte);
            if (step == VARINT_TOO_LONG) begin
              made.push_back(record(ST_TRUNCATED, '0, '0, past));
              halted = 1'b1;
            end else if (step == VARINT_DONE) begin
              tag   = acc;
              acc   = '0;
              count = '0;
              case (tag[2:0])
                WT_VARINT: phase = VARINT_VALUE;
                WT_LEN:    phase = LENGTH_VALUE;
                WT_FIXED64, WT_FIXED8, WT_FIXED16, WT_FIXED32: phase = FIXED_VALUE;
                default: begin
                  made.push_back(record(ST_INVALID, tag, '0, past));
                  halted = 1'b1;
                end
              endcase
            end
          end
          VARINT_VALUE, LENGTH_VALUE: begin
            step = absorb_varint(it.data_byte);
            if (step == VARINT_TOO_LONG) begin
              made.push_back(record(ST_TRUNCATED, tag, '0, past));
              halted = 1'b1;
            end else if (step == VARINT_DONE) begin
              made.push_back(record(ST_FIELD, tag, acc, start));
              // A zero length has no payload to skip.
              if (phase == LENGTH_VALUE && acc != 0) begin
                remaining = acc;
                phase     = SKIP_PAYLOAD;
              end else begin
                phase = AWAIT_TAG;
              end
              acc   = '0;
              count = '0;
            end
          end
          FIXED_VALUE: begin
            case (tag[2:0])
              WT_FIXED64: need = 4'd8;
              WT_FIXED8:  need = 4'd1;
              WT_FIXED16: need = 4'd2;
              default:    need = 4'd4;
            endcase
            if (count < 8) acc |= {56'd0, it.data_byte} << (8 * count);
            count++;
            if (count >= need) begin
              made.push_back(record(ST_FIELD, tag, acc, start));
              acc   = '0;
              count = '0;
              phase = AWAIT_TAG;
            end
          end
          SKIP_PAYLOAD: begin
            if (remaining != 0) remaining--;
            if (remaining == 0) phase = AWAIT_TAG;
          end
          default: ;
        endcase
      end
      if (it.end_of_buffer) begin
        if (!halted) begin
          if (phase == AWAIT_TAG && count == 0)
            made.push_back(record(ST_DONE, '0, '0, past));
          else if (phase == SKIP_PAYLOAD)
            made.push_back(record(ST_LEN_PAST, tag, remaining, past));
          else if (phase == AWAIT_TAG)
            made.push_back(record(ST_TRUNCATED, '0, '0, past));
          else
            made.push_back(record(ST_TRUNCATED, tag, '0, past));
        end
        restart();
      end else begin
        pos = past;
      end
      if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
      foreach (made[i]) awaited_records.push_back(made[i]);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
        failures++;
      end
    endfunction

    function void check_record(out_item_t got);
      out_item_t want;
      if (awaited_records.size() == 0) begin
        $display("%0t ns: unexpected record, expected none, got %p", $time, got);
        failures++;
        return;
      end
      want = awaited_records.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("field_id", want.field_id, got.field_id);
      compare_field("wire_type", want.wire_type, got.wire_type);
      compare_field("field_value", want.field_value, got.field_value);
      compare_field("field_offset", want.field_offset, got.field_offset);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

endpackage

@@ dv/wire_format_field_tokenizer_tb.sv @@
`timescale 1ns / 1ps

module wire_format_field_tokenizer_tb;
  import wft_pkg::*;
  import field_record_tracker_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int LONG_HOLD   = 64;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  field_record_tracker tracker;
  in_item_t            byte_plan[$];
  int                  bytes_taken = 0;
  int                  msg = 0;
  bit                  steady = 1'b0;
  bit                  hold_request = 1'b0;

  wire_format_field_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void put_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte     = b;
    it.end_of_buffer = 1'b0;
    byte_plan.push_back(it);
  endfunction

  function automatic void end_buffer();
    in_item_t it;
    it = byte_plan.pop_back();
    it.end_of_buffer = 1'b1;
    byte_plan.push_back(it);
  endfunction

  function automatic void put_varint(logic [63:0] v);
    logic [6:0] low;
    do begin
      low = v[6:0];
      v   = v >> 7;
      put_byte({v != 0, low});
    end while (v != 0);
  endfunction

  // Random content, which may be padded and may carry bits beyond the 64th.
  function automatic void put_raw_varint(int n);
    for (int i = 0; i < n; i++) put_byte({i < n - 1, 7'($urandom)});
  endfunction

  function automatic void put_tag(logic [2:0] wt);
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 10) : 1;
    put_byte({n > 1, 4'($urandom), wt});
    for (int i = 1; i < n; i++) put_byte({i < n - 1, 7'($urandom)});
  endfunction

  function automatic void plan_field();
    logic [2:0] wt;
    int         len;
    wt = 3'($urandom_range(WT_VARINT, WT_FIXED32));
    put_tag(wt);
    case (wt)
      WT_VARINT:
        put_raw_varint(($urandom_range(0, 3) == 0) ? $urandom_range(4, 10)
                                                   : $urandom_range(1, 3));
      WT_FIXED64: repeat (8) put_byte(8'($urandom));
      WT_LEN: begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 6);
        put_varint(len);
        repeat (len) put_byte(8'($urandom));
      end
      WT_FIXED8:  put_byte(8'($urandom));
      WT_FIXED16: repeat (2) put_byte(8'($urandom));
      default:    repeat (4) put_byte(8'($urandom));
    endcase
  endfunction

  // Mostly well-formed buffers; the rest end early, carry a bad wire type, an
  // endless varint, a payload that runs off the end, or plain noise.
  function automatic void plan_message();
    int kind = $urandom_range(0, 99);
    int base = byte_plan.size();
    int nf;
    int cut;
    int len;
    nf = (kind >= 94) ? 0 : $urandom_range(1, 4);
    repeat (nf) plan_field();
    if (kind < 65) begin
    end else if (kind < 75) begin
      cut = $urandom_range(base, byte_plan.size() - 1);
      while (byte_plan.size() > cut + 1) void'(byte_plan.pop_back());
    end else if (kind < 82) begin
      put_tag(3'($urandom_range(WT_BAD_LO, WT_BAD_HI)));
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
    end else if (kind < 88) begin
      if ($urandom_range(0, 1)) put_tag(WT_VARINT);
      repeat ($urandom_range(10, 12)) put_byte(8'h80 | 8'($urandom));
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
    end else if (kind < 94) begin
      len = $urandom_range(1, 20);
      put_tag(WT_LEN);
      put_varint(len);
      repeat ($urandom_range(0, len - 1)) put_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 16)) begin
        put_byte(8'($urandom));
        if ($urandom_range(0, 7) == 0) end_buffer();
      end
    end
    end_buffer();
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_byte(it);
    bytes_taken++;
    @(negedge clk);
  endtask

  task automatic send_plan();
    foreach (byte_plan[i]) send_byte(byte_plan[i]);
    byte_plan.delete();
  endtask

  task automatic wait_for_records();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.awaited_records.size() != 0);
  endtask

  initial begin
    tracker = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // A varint field completed by the last byte gives a field and a done record.
    put_byte(8'h08); put_byte(8'h96); put_byte(8'h01); end_buffer();
    // Four-byte fixed, then a length-delimited field whose payload is skipped.
    put_byte(8'h1D); put_byte(8'h00); put_byte(8'h00); put_byte(8'h80);
    put_byte(8'hFF); put_byte(8'h12); put_byte(8'h02); put_byte(8'hAA);
    put_byte(8'hBB); end_buffer();
    put_byte(8'h1B); put_byte(8'h7F); put_byte(8'h20); put_byte(8'h34);
    put_byte(8'h12); end_buffer();
    // Wire type seven stops the parse; the rest of the buffer is ignored.
    put_byte(8'h0F); put_byte(8'h55); put_byte(8'h66); end_buffer();
    put_byte(8'h0A); put_byte(8'h05); put_byte(8'h01); put_byte(8'h02); end_buffer();
    put_byte(8'h80); end_buffer();
    send_plan();

    while (bytes_taken < ITEM_TARGET) begin
      steady = (msg % 40) >= 30;
      if (msg == 34) hold_request = 1'b1;
      if (msg % 25 == 24) wait_for_records();
      plan_message();
      send_plan();
      msg++;
    end

    wait_for_records();
    repeat (20) @(negedge clk);
    if (tracker.failures == 0)
      $display("wire_format_field_tokenizer_tb: clean");
    else
      $display("wire_format_field_tokenizer_tb: errors");
    $finish;
  end

  initial begin
    int gap;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = hold_request ? LONG_HOLD : (steady ? 0 : $urandom_range(0, 8));
      hold_request = 1'b0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_record(out_data);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("wire_format_field_tokenizer_tb: errors");
    $finish;
  end

endmodule

@@ wire_format_field_tokenizer.f @@
+incdir+src
src/wft_pkg.sv
src/wire_format_field_tokenizer.sv
src/wft_checker.sv
dv/field_record_tracker_pkg.sv
dv/wire_format_field_tokenizer_tb.sv
